/* rtl/tdq_pkg.sv */
// ----------------------------------------------------------------------------
// tdq_pkg
// shared types and constants of the timer deadline queue
// ----------------------------------------------------------------------------
package tdq_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int SLOT_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
  localparam int TIME_W     = 63;

  typedef enum logic [0:0] {
    FUNC_ADD  = 1'b0,
    FUNC_TICK = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    KIND_ADDED   = 2'd0,
    KIND_FULL    = 2'd1,
    KIND_EXPIRED = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef struct packed {
    logic [0:0]        func;
    logic [TIME_W-1:0] expiry_time;
    logic [TIME_W-1:0] interval_us;
    logic [TIME_W-1:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [3:0]        timer_id;
    logic              last;
    logic              earliest_changed;
    logic [TIME_W-1:0] next_deadline;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,      // read every slot once: min, free slot, due set
    ST_SCAN_END,
    ST_ADD_WR,
    ST_PICK,      // per expiry: search due slots for (deadline, slot) minimum
    ST_PICK_END,
    ST_REARM,
    ST_MIN,       // final earliest search after updates
    ST_MIN_END,
    ST_EMIT
  } state_t;

endpackage

/* rtl/timer_deadline_queue.sv */
// ----------------------------------------------------------------------------
// timer_deadline_queue
// timer slots with deadlines and repeat intervals, expiry in deadline order
// ----------------------------------------------------------------------------
// Deadlines and intervals sit in a one-port-read synchronous memory that is
// walked one slot per cycle; valid bits are flip-flops. An add scans all
// slots, writes the free slot and searches the earliest; a full add or a tick
// with nothing due only scans. A tick with expired timers runs one pass that
// finds the due set, one pass per expiry that picks the next in (deadline,
// slot) order, and one pass that finds the new earliest. Results of a tick
// come out after all updates, one per cycle, with busy high until the last.
// The receiver cannot stall: each result is valid for exactly one cycle while
// out_valid is high.
module timer_deadline_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tdq_pkg::in_item_t  in_item,
  output logic               out_valid,
  output tdq_pkg::out_item_t out_item
);
  import tdq_pkg::*;

  // memories: deadline and interval per slot
  logic [TIME_W-1:0] dl_mem [NUM_TIMERS];
  logic [TIME_W-1:0] iv_mem [NUM_TIMERS];
  logic [TIME_W-1:0] dl_rd, iv_rd;
  logic [SLOT_W-1:0] rd_addr;
  logic              wr_dl_en, wr_iv_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [TIME_W-1:0] wr_dl, wr_iv;

  always_ff @(posedge clk) begin
    if (wr_dl_en) dl_mem[wr_addr] <= wr_dl;
    if (wr_iv_en) iv_mem[wr_addr] <= wr_iv;
    dl_rd <= dl_mem[rd_addr];
    iv_rd <= iv_mem[rd_addr];
  end

  state_t state_r, state_nxt;
  logic [NUM_TIMERS-1:0] valid_r, valid_nxt;
  logic [NUM_TIMERS-1:0] due_r, due_nxt;
  logic [NUM_TIMERS-1:0] done_r, done_nxt;   // picked this tick
  in_item_t              item_r;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;     // read address counter
  logic [SLOT_W-1:0]     rslot_r;            // slot whose data is on dl_rd
  logic                  rvld_r;
  logic                  any_r, any_nxt;
  logic [TIME_W-1:0]     best_r, best_nxt;
  logic [SLOT_W-1:0]     bslot_r, bslot_nxt;
  logic                  free_f_r, free_f_nxt;
  logic [SLOT_W-1:0]     free_r, free_nxt;
  logic                  chg_r, chg_nxt;
  logic [SLOT_W-1:0]     order_r [NUM_TIMERS];
  logic [CNT_W-1:0]      n_r, n_nxt;
  logic [CNT_W-1:0]      e_r, e_nxt;
  logic [1:0]            kind_r, kind_nxt;
  logic                  ord_we;

  logic [TIME_W:0]       rearm_sum;
  logic                  scan_last;

  assign scan_last = (cnt_r == CNT_W'(NUM_TIMERS));
  // the picked slot is read ahead so its interval is ready for the re-arm
  assign rd_addr   = (state_r == ST_PICK_END) ? bslot_r : cnt_r[SLOT_W-1:0];
  assign rearm_sum = {1'b0, item_r.now_time} + {1'b0, iv_rd};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (start) state_nxt = ST_SCAN;
      ST_SCAN:     if (scan_last) state_nxt = ST_SCAN_END;
      ST_SCAN_END: begin
        if (item_r.func == FUNC_ADD) begin
          state_nxt = free_f_r ? ST_ADD_WR : ST_EMIT;
        end else begin
          state_nxt = (due_r == '0) ? ST_EMIT : ST_PICK;
        end
      end
      ST_ADD_WR:   state_nxt = ST_MIN;
      ST_PICK:     if (scan_last) state_nxt = ST_PICK_END;
      ST_PICK_END: state_nxt = ST_REARM;
      ST_REARM:    state_nxt = ((due_r & ~done_nxt) == '0) ? ST_MIN : ST_PICK;
      ST_MIN:      if (scan_last) state_nxt = ST_MIN_END;
      ST_MIN_END:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (kind_r != KIND_EXPIRED || e_r + CNT_W'(1) >= n_r) state_nxt = ST_IDLE;
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    valid_nxt  = valid_r;
    due_nxt    = due_r;
    done_nxt   = done_r;
    cnt_nxt    = cnt_r;
    any_nxt    = any_r;
    best_nxt   = best_r;
    bslot_nxt  = bslot_r;
    free_f_nxt = free_f_r;
    free_nxt   = free_r;
    chg_nxt    = chg_r;
    n_nxt      = n_r;
    e_nxt      = e_r;
    kind_nxt   = kind_r;
    ord_we     = 1'b0;
    wr_dl_en   = 1'b0;
    wr_iv_en   = 1'b0;
    wr_addr    = bslot_r;
    wr_dl      = item_r.expiry_time;
    wr_iv      = item_r.interval_us;
    busy       = (state_r != ST_IDLE);
    out_valid  = 1'b0;
    out_item   = '0;

    if (state_r != ST_IDLE && state_r != ST_EMIT && !scan_last)
      cnt_nxt = cnt_r + CNT_W'(1);

    case (state_r)
      ST_IDLE: begin
        cnt_nxt    = '0;
        any_nxt    = 1'b0;
        free_f_nxt = 1'b0;
        due_nxt    = '0;
        done_nxt   = '0;
        n_nxt      = '0;
        e_nxt      = '0;
        if (start) cnt_nxt = '0;
      end
      ST_SCAN, ST_SCAN_END: begin
        if (rvld_r) begin
          if (valid_r[rslot_r]) begin
            if (!any_r || dl_rd < best_r) best_nxt = dl_rd;
            any_nxt = 1'b1;
            if (item_r.func == FUNC_TICK && dl_rd <= item_r.now_time)
              due_nxt[rslot_r] = 1'b1;
          end else if (!free_f_r) begin
            free_f_nxt = 1'b1;
            free_nxt   = rslot_r;
          end
        end
        if (state_r == ST_SCAN_END) begin
          cnt_nxt = '0;
          if (item_r.func == FUNC_ADD) begin
            if (free_f_r) begin
              chg_nxt  = !any_r || item_r.expiry_time < best_r;
              kind_nxt = KIND_ADDED;
            end else begin
              chg_nxt  = 1'b0;
              kind_nxt = KIND_FULL;
            end
          end else begin
            chg_nxt  = 1'b0;
            kind_nxt = (due_r == '0) ? KIND_NONE : KIND_EXPIRED;
          end
          // nothing changes on a full add or an idle tick: keep the earliest
          if (item_r.func == FUNC_TICK && due_r != '0) any_nxt = 1'b0;
        end
      end
      ST_ADD_WR: begin
        wr_addr          = free_r;
        wr_dl_en         = 1'b1;
        wr_iv_en         = 1'b1;
        valid_nxt[free_r] = 1'b1;
        cnt_nxt          = '0;
        any_nxt          = 1'b0;
        bslot_nxt        = free_r;
      end
      ST_PICK, ST_PICK_END: begin
        // strict compare keeps the lowest slot among equal deadlines
        if (rvld_r && due_r[rslot_r] && !done_r[rslot_r]) begin
          if (!any_r || dl_rd < best_r) begin
            best_nxt  = dl_rd;
            bslot_nxt = rslot_r;
          end
          any_nxt = 1'b1;
        end
        if (state_r == ST_PICK_END) cnt_nxt = CNT_W'(bslot_nxt);
      end
      ST_REARM: begin
        // the read in the previous cycle addressed bslot, so iv_rd is its interval
        ord_we            = 1'b1;
        done_nxt[bslot_r] = 1'b1;
        n_nxt             = n_r + CNT_W'(1);
        wr_addr           = bslot_r;
        if (iv_rd != '0) begin
          wr_dl_en = 1'b1;
          wr_dl    = rearm_sum[TIME_W] ? {TIME_W{1'b1}} : rearm_sum[TIME_W-1:0];
        end else begin
          valid_nxt[bslot_r] = 1'b0;
        end
        cnt_nxt = '0;
        any_nxt = 1'b0;
      end
      ST_MIN, ST_MIN_END: begin
        if (rvld_r && valid_r[rslot_r]) begin
          if (!any_r || dl_rd < best_r) best_nxt = dl_rd;
          any_nxt = 1'b1;
        end
        if (state_r == ST_MIN_END) cnt_nxt = '0;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        out_item.kind             = kind_r;
        out_item.earliest_changed = chg_r;
        out_item.next_deadline    = any_r ? best_r : '0;
        case (kind_r)
          KIND_ADDED:   out_item.timer_id = 4'(free_r);
          KIND_EXPIRED: out_item.timer_id = 4'(order_r[e_r[SLOT_W-1:0]]);
          default:      out_item.timer_id = 4'd0;
        endcase
        out_item.last = (kind_r != KIND_EXPIRED) || (e_r + CNT_W'(1) >= n_r);
        e_nxt = e_r + CNT_W'(1);
      end
      default: ;
    endcase
  end

  // full add skips the write, but still reports the earliest held
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      valid_r  <= '0;
      rvld_r   <= 1'b0;
      cnt_r    <= '0;
      e_r      <= '0;
      n_r      <= '0;
      due_r    <= '0;
      done_r   <= '0;
      any_r    <= 1'b0;
      free_f_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      valid_r  <= valid_nxt;
      cnt_r    <= cnt_nxt;
      e_r      <= e_nxt;
      n_r      <= n_nxt;
      due_r    <= due_nxt;
      done_r   <= done_nxt;
      any_r    <= any_nxt;
      free_f_r <= free_f_nxt;
      // read data is good when the address counter stood on a slot
      // and no write to that slot was under way
      rvld_r   <= (state_r == ST_SCAN || state_r == ST_PICK || state_r == ST_MIN ||
                   (state_r == ST_IDLE && start) || state_r == ST_SCAN_END ||
                   state_r == ST_PICK_END) && !scan_last;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) item_r <= in_item;
    rslot_r <= rd_addr;
    best_r  <= best_nxt;
    bslot_r <= bslot_nxt;
    free_r  <= free_nxt;
    chg_r   <= chg_nxt;
    kind_r  <= kind_nxt;
    if (ord_we) order_r[n_r[SLOT_W-1:0]] <= bslot_r;
  end

endmodule
